[rtl/core/cirlf_pkg.sv]
package cirlf_pkg;

	localparam int unsigned ID_W   = 11;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned LEN_W  = 4;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned CNT_OUT_W = 5;

	localparam logic [LEN_W-1:0]  MAX_LEN        = 4'd8;
	localparam logic [TIME_W-1:0] RESET_INTERVAL = 32'd100;

	localparam logic [1:0] OP_FRAME  = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ID_W-1:0]   can_id;
		logic [TIME_W-1:0] now_ms;
		logic [LEN_W-1:0]  frame_len;
		logic [DATA_W-1:0] frame_data;
	} in_word_t;

	typedef struct packed {
		logic                 pass;
		logic [ID_W-1:0]      out_id;
		logic [LEN_W-1:0]     out_len;
		logic [DATA_W-1:0]    out_data;
		logic [TIME_W-1:0]    out_time;
		logic                 op_done;
		logic [CNT_OUT_W-1:0] entry_count;
	} out_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] last_ms;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic move_rd;
		logic move_wr;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic move_need;
	} ctl_sts_t;

endpackage

[rtl/core/cirlf_ctrl.sv]
module cirlf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cirlf_pkg::ctl_sts_t sts,
	output cirlf_pkg::ctl_cmd_t cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE_RD,
		ST_MOVE_WR
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_end) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (sts.move_need) begin
						state_q <= ST_MOVE_RD;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_MOVE_RD: begin
					state_q <= ST_MOVE_WR;
				end
				ST_MOVE_WR: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.scan    = (state_q == ST_SCAN);
		cmd.decide  = (state_q == ST_DECIDE);
		cmd.move_rd = (state_q == ST_MOVE_RD);
		cmd.move_wr = (state_q == ST_MOVE_WR);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

[rtl/core/cirlf_dp.sv]
module cirlf_dp #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cirlf_pkg::in_word_t                     req,
	input  logic                                    cfg_we,
	input  logic [cirlf_pkg::TIME_W-1:0]            cfg_wdata,
	input  cirlf_pkg::ctl_cmd_t                     cmd,
	output cirlf_pkg::ctl_sts_t                     sts,
	output cirlf_pkg::out_word_t                    result
);

	localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

	cirlf_pkg::entry_t mem [TABLE_DEPTH];

	cirlf_pkg::in_word_t           req_q;
	cirlf_pkg::out_word_t          res_q;
	cirlf_pkg::out_word_t          res_d;
	cirlf_pkg::entry_t             rd_q;
	cirlf_pkg::entry_t             wr_data;
	logic [cirlf_pkg::TIME_W-1:0]  interval_q;
	logic [cirlf_pkg::TIME_W-1:0]  hit_time_q;
	logic [cirlf_pkg::TIME_W-1:0]  elapsed;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              count_d;
	logic [CNT_W-1:0]              idx_q;
	logic [CNT_W-1:0]              last_idx;
	logic [ADDR_W-1:0]             rd_addr;
	logic [ADDR_W-1:0]             wr_addr;
	logic [ADDR_W-1:0]             rd_addr_s1;
	logic [ADDR_W-1:0]             hit_idx_q;
	logic                          rd_valid_s1;
	logic                          hit_q;
	logic                          match;
	logic                          scan_rd;
	logic                          rd_en;
	logic                          wr_en;
	logic [cirlf_pkg::LEN_W-1:0]   len_clamp;
	logic [cirlf_pkg::DATA_W-1:0]  data_mask;

	assign match    = rd_valid_s1 && !hit_q && (rd_q.id == req_q.can_id);
	assign scan_rd  = cmd.scan && !hit_q && !match && (idx_q != count_q);
	assign last_idx = count_q - CNT_W'(1);
	assign rd_en    = scan_rd || cmd.move_rd;
	assign rd_addr  = cmd.move_rd ? last_idx[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
	assign elapsed  = req_q.now_ms - hit_time_q;

	assign sts.scan_end  = hit_q || match || ((idx_q == count_q) && !rd_valid_s1);
	assign sts.move_need = (req_q.opcode == cirlf_pkg::OP_DELETE) && hit_q;

	always_comb begin
		len_clamp = (req_q.frame_len > cirlf_pkg::MAX_LEN) ? cirlf_pkg::MAX_LEN
			: req_q.frame_len;
		for (int b = 0; b < 8; b++) begin
			data_mask[b*8 +: 8] = (4'(b) < len_clamp) ? 8'hFF : 8'h00;
		end
	end

	always_comb begin
		res_d             = '0;
		res_d.entry_count = cirlf_pkg::CNT_OUT_W'(count_q);
		count_d           = count_q;
		wr_en             = 1'b0;
		wr_addr           = hit_idx_q;
		wr_data.id        = req_q.can_id;
		wr_data.last_ms   = req_q.now_ms;
		if (cmd.decide) begin
			case (req_q.opcode)
				cirlf_pkg::OP_FRAME: begin
					if (hit_q && ((interval_q == '0) || (elapsed >= interval_q))) begin
						wr_en          = 1'b1;
						res_d.pass     = 1'b1;
						res_d.out_id   = req_q.can_id;
						res_d.out_len  = len_clamp;
						res_d.out_data = req_q.frame_data & data_mask;
						res_d.out_time = req_q.now_ms;
					end
				end
				cirlf_pkg::OP_ADD: begin
					if (!hit_q && (req_q.can_id != '0) && (count_q != FULL)) begin
						wr_en             = 1'b1;
						wr_addr           = count_q[ADDR_W-1:0];
						wr_data.last_ms   = '0;
						count_d           = count_q + CNT_W'(1);
						res_d.op_done     = 1'b1;
						res_d.entry_count = cirlf_pkg::CNT_OUT_W'(count_d);
					end
				end
				cirlf_pkg::OP_DELETE: begin
					if (hit_q) begin
						res_d.op_done     = 1'b1;
						res_d.entry_count = cirlf_pkg::CNT_OUT_W'(last_idx);
					end
				end
				cirlf_pkg::OP_CLEAR: begin
					if (count_q != '0) begin
						count_d           = '0;
						res_d.op_done     = 1'b1;
						res_d.entry_count = '0;
					end
				end
				default: begin
					res_d = '0;
				end
			endcase
		end else if (cmd.move_wr) begin
			wr_en   = 1'b1;
			wr_data = rd_q;
			count_d = last_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= cirlf_pkg::RESET_INTERVAL;
			count_q     <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_wdata;
			end
			count_q     <= count_d;
			rd_valid_s1 <= scan_rd;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (scan_rd) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (scan_rd) begin
			rd_addr_s1 <= idx_q[ADDR_W-1:0];
		end
		if (match) begin
			hit_idx_q  <= rd_addr_s1;
			hit_time_q <= rd_q.last_ms;
		end
		if (cmd.decide) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

[rtl/core/can_id_rate_limited_filter.sv]
// CAN identifier filter with a per-identifier rate limit.
// A command word is presented on req and taken at a clock edge where start is
// high and busy is low. The opcode selects a frame check, an add, a delete or
// a clear of the watched identifier table.
// The table lives in a single-port memory that is scanned one entry per cycle
// with a registered read, so the time one word takes grows with count, the
// number of watched identifiers; a delete then moves the last entry into the
// freed slot. The scan through the table memory sets this time.
// Exactly one result word follows each command. It is shown on result for one
// cycle while done is high; the receiver cannot stall, so the word must be
// taken in that cycle. A new command may be started in the same cycle.
// The user must write the interval register (cfg_we, cfg_wdata) only while
// idle; the block does not enforce it. It takes effect at the next command.
// Reset empties the table and sets the interval to 100 milliseconds.
module can_id_rate_limited_filter #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cirlf_pkg::in_word_t          req,
	output logic                         done,
	output cirlf_pkg::out_word_t         result,
	input  logic                         cfg_we,
	input  logic [cirlf_pkg::TIME_W-1:0] cfg_wdata
);

	cirlf_pkg::ctl_cmd_t cmd;
	cirlf_pkg::ctl_sts_t sts;

	cirlf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cirlf_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule
